>>> design/shell_block_history_flattener_macros.svh
// Assertion macros used by the shell block history flattener checker.
`ifndef SHELL_BLOCK_HISTORY_FLATTENER_MACROS_SVH
`define SHELL_BLOCK_HISTORY_FLATTENER_MACROS_SVH

// Same-cycle implication, clocked on clk_i, disabled in reset.
`define SBHF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, disabled in reset.
`define SBHF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/sbhf_pkg.sv
// Types, constants and helper functions of the shell block history flattener.
package sbhf_pkg;

  localparam int WORD_BUF_LEN     = 8;
  localparam int MAX_OUT_CAPACITY = 8192;

  localparam int CAP_W  = 14;
  localparam int WIDX_W = $clog2(WORD_BUF_LEN);
  localparam int WLEN_W = $clog2(WORD_BUF_LEN + 2);
  localparam int CNT_W  = $clog2(MAX_OUT_CAPACITY);
  localparam int CMP_W  = ((CNT_W + 2) > CAP_W) ? (CNT_W + 2) : CAP_W;
  localparam int MAX_RES = 3;
  localparam int RCNT_W  = 2;

  localparam logic [WLEN_W-1:0] WORD_FULL = WLEN_W'(WORD_BUF_LEN);
  localparam logic [WLEN_W-1:0] WORD_OVF  = WLEN_W'(WORD_BUF_LEN + 1);
  localparam logic [CAP_W-1:0]  CAP_RST   = CAP_W'(MAX_OUT_CAPACITY);
  localparam logic [CMP_W-1:0]  CAP_MAX   = CMP_W'(MAX_OUT_CAPACITY);

  localparam logic [7:0] CHR_NUL    = 8'h00;
  localparam logic [7:0] CHR_TAB    = 8'h09;
  localparam logic [7:0] CHR_NL     = 8'h0A;
  localparam logic [7:0] CHR_VT     = 8'h0B;
  localparam logic [7:0] CHR_FF     = 8'h0C;
  localparam logic [7:0] CHR_CR     = 8'h0D;
  localparam logic [7:0] CHR_SPACE  = 8'h20;
  localparam logic [7:0] CHR_DQUOTE = 8'h22;
  localparam logic [7:0] CHR_SQUOTE = 8'h27;
  localparam logic [7:0] CHR_SEMI   = 8'h3B;
  localparam logic [7:0] CHR_BSLASH = 8'h5C;

  localparam logic [31:0] KW_THEN  = "then";
  localparam logic [31:0] KW_ELSE  = "else";
  localparam logic [31:0] KW_ELIF  = "elif";
  localparam logic [15:0] KW_DO    = "do";
  localparam logic [15:0] KW_IN    = "in";
  localparam logic [7:0]  KW_BRACE = "{";

  typedef logic [WORD_BUF_LEN-1:0][7:0] word_buf_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       text_end;
    logic       truncated;
  } res_t;

  typedef struct packed {
    logic [RCNT_W-1:0]     cnt;
    res_t [MAX_RES-1:0]    ent;
  } batch_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CHR_SPACE) || (c == CHR_TAB) || (c == CHR_NL) ||
           (c == CHR_VT) || (c == CHR_FF) || (c == CHR_CR);
  endfunction

  function automatic logic is_keyword(input word_buf_t w, input logic [WLEN_W-1:0] len);
    logic [31:0] w4;
    logic [15:0] w2;
    w4 = {w[0], w[1], w[2], w[3]};
    w2 = {w[0], w[1]};
    return ((len == WLEN_W'(4)) && ((w4 == KW_THEN) || (w4 == KW_ELSE) || (w4 == KW_ELIF))) ||
           ((len == WLEN_W'(2)) && ((w2 == KW_DO) || (w2 == KW_IN))) ||
           ((len == WLEN_W'(1)) && (w[0] == KW_BRACE));
  endfunction

endpackage

>>> design/sbhf_core.sv
// Quote, escape and word tracking; builds the result batch of one input byte.
module sbhf_core import sbhf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [7:0]       in_byte_i,
  input  logic             end_of_block_i,
  input  logic [CAP_W-1:0] cap_i,
  output batch_t           batch_o
);

  logic              sq_q, sq_d;
  logic              dq_q, dq_d;
  logic              esc_q, esc_d;
  logic              drop_q, drop_d;
  logic [WLEN_W-1:0] len_q, len_d;
  logic [CNT_W-1:0]  emit_q;
  word_buf_t         wbuf_q;

  logic              wr_en;
  logic [1:0]        ne;
  logic [7:0]        em0, em1;
  logic [CMP_W-1:0]  cap_eff, emit_ext;
  logic              room1, room2;
  res_t              term;

  always_comb begin
    cap_eff = CMP_W'(cap_i);
    if (cap_eff == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_eff > CAP_MAX) begin
      cap_eff = CAP_MAX;
    end
    emit_ext = CMP_W'(emit_q);
    room1    = (emit_ext + CMP_W'(1)) < cap_eff;
    room2    = (emit_ext + CMP_W'(2)) < cap_eff;
  end

  always_comb begin
    sq_d   = sq_q;
    dq_d   = dq_q;
    esc_d  = esc_q;
    drop_d = drop_q;
    len_d  = len_q;
    wr_en  = 1'b0;
    ne     = 2'd0;
    em0    = in_byte_i;
    em1    = CHR_SPACE;
    if (!room1) begin
      drop_d = 1'b1;
    end else if (esc_q) begin
      esc_d = 1'b0;
      ne    = 2'd1;
      if (len_q < WORD_FULL) begin
        wr_en = 1'b1;
        len_d = len_q + WLEN_W'(1);
      end
    end else if (!sq_q && in_byte_i == CHR_BSLASH) begin
      esc_d = 1'b1;
      ne    = 2'd1;
    end else if (!dq_q && in_byte_i == CHR_SQUOTE) begin
      sq_d = ~sq_q;
      ne   = 2'd1;
    end else if (!sq_q && in_byte_i == CHR_DQUOTE) begin
      dq_d = ~dq_q;
      ne   = 2'd1;
    end else if (in_byte_i == CHR_NL && !sq_q && !dq_q) begin
      if (len_q != '0) begin
        ne = 2'd1;
        if (is_keyword(wbuf_q, len_q)) begin
          em0 = CHR_SPACE;
        end else begin
          em0 = CHR_SEMI;
          if (room2) begin
            ne = 2'd2;
          end else begin
            drop_d = 1'b1;
          end
        end
      end
      len_d = '0;
    end else if (in_byte_i == CHR_NL) begin
      ne  = 2'd1;
      em0 = CHR_SPACE;
    end else begin
      ne = 2'd1;
      if (!sq_q && !dq_q) begin
        if (is_ws(in_byte_i)) begin
          len_d = '0;
        end else if (len_q < WORD_FULL) begin
          wr_en = 1'b1;
          len_d = len_q + WLEN_W'(1);
        end else begin
          len_d = WORD_OVF;
        end
      end
    end
  end

  always_comb begin
    term.out_byte  = CHR_NUL;
    term.run_last  = 1'b1;
    term.text_end  = 1'b1;
    term.truncated = drop_d;

    batch_o.cnt = ne + RCNT_W'(end_of_block_i);
    batch_o.ent[2] = term;
    if (ne == 2'd2) begin
      batch_o.ent[1].out_byte  = em1;
      batch_o.ent[1].run_last  = !end_of_block_i;
      batch_o.ent[1].text_end  = 1'b0;
      batch_o.ent[1].truncated = drop_d;
    end else begin
      batch_o.ent[1] = term;
    end
    if (ne != 2'd0) begin
      batch_o.ent[0].out_byte  = em0;
      batch_o.ent[0].run_last  = !end_of_block_i && (ne == 2'd1);
      batch_o.ent[0].text_end  = 1'b0;
      batch_o.ent[0].truncated = drop_d;
    end else begin
      batch_o.ent[0] = term;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_q   <= 1'b0;
      dq_q   <= 1'b0;
      esc_q  <= 1'b0;
      drop_q <= 1'b0;
      len_q  <= '0;
      emit_q <= '0;
    end else if (fire_i) begin
      if (end_of_block_i) begin
        sq_q   <= 1'b0;
        dq_q   <= 1'b0;
        esc_q  <= 1'b0;
        drop_q <= 1'b0;
        len_q  <= '0;
        emit_q <= '0;
      end else begin
        sq_q   <= sq_d;
        dq_q   <= dq_d;
        esc_q  <= esc_d;
        drop_q <= drop_d;
        len_q  <= len_d;
        emit_q <= emit_q + CNT_W'(ne);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && wr_en) begin
      wbuf_q[len_q[WIDX_W-1:0]] <= in_byte_i;
    end
  end

endmodule

>>> design/sbhf_outq.sv
// Result buffer: holds one byte's batch and drains it one transaction per cycle while out_ready_i is high.
module sbhf_outq import sbhf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  batch_t     batch_i,
  output logic       space_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output res_t       head_o
);

  res_t [MAX_RES-1:0] slot_q, slot_d;
  logic [RCNT_W-1:0]  cnt_q, cnt_d;
  logic               pop;

  assign out_valid_o = (cnt_q != '0);
  assign head_o      = slot_q[0];
  assign pop         = out_valid_o && out_ready_i;
  assign space_o     = (cnt_q == '0) || ((cnt_q == RCNT_W'(1)) && out_ready_i);

  always_comb begin
    slot_d = slot_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      slot_d = batch_i.ent;
      cnt_d  = batch_i.cnt;
    end else if (pop) begin
      slot_d[0] = slot_q[1];
      slot_d[1] = slot_q[2];
      cnt_d     = cnt_q - RCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

endmodule

>>> design/shell_block_history_flattener.sv
// Shell block history flattener top level.
// Latency: first result of a byte is valid the cycle after the byte's transaction.
// Throughput: one byte per cycle while out_ready_i is high and each byte yields at most
//   one result; a byte with more results holds the input until its last result drains.
// Reset (async, active low): quote, escape, word and count state clear, capacity
//   returns to 8192, result buffer empties; the word byte buffer is not reset.
module shell_block_history_flattener import sbhf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       in_byte_i,
  input  logic             end_of_block_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       out_byte_o,
  output logic             run_last_o,
  output logic             text_end_o,
  output logic             truncated_o,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_wdata_i
);

  logic [CAP_W-1:0] cap_q;
  logic             fire;
  batch_t           batch;
  res_t             head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RST;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  assign fire = in_valid_i && in_ready_o;

  sbhf_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .in_byte_i     (in_byte_i),
    .end_of_block_i(end_of_block_i),
    .cap_i         (cap_q),
    .batch_o       (batch)
  );

  sbhf_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (fire),
    .batch_i    (batch),
    .space_o    (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .head_o     (head)
  );

  assign out_byte_o  = head.out_byte;
  assign run_last_o  = head.run_last;
  assign text_end_o  = head.text_end;
  assign truncated_o = head.truncated;

endmodule

>>> design/sbhf_checker.sv
// Port-level checks for the shell block history flattener, bound to the top level.
`include "shell_block_history_flattener_macros.svh"

module sbhf_checker import sbhf_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic       run_last_o,
  input logic       text_end_o,
  input logic       truncated_o
);

  logic term_seen;
  logic out_stall;
  logic mid_run;

  assign term_seen = out_valid_o && text_end_o;
  assign out_stall = out_valid_o && !out_ready_i;
  assign mid_run   = out_valid_o && out_ready_i && !run_last_o;

  `SBHF_ASSERT_IMP(a_term_is_last, term_seen, run_last_o, "terminator without run_last")
  `SBHF_ASSERT_IMP(a_term_is_nul, term_seen, out_byte_o == CHR_NUL, "terminator byte not zero")
  `SBHF_ASSERT_NXT(a_out_hold, out_stall, out_valid_o && $stable(out_byte_o), "result dropped")
  `SBHF_ASSERT_NXT(a_run_cont, mid_run, out_valid_o && $stable(truncated_o), "run broken")

endmodule

bind shell_block_history_flattener sbhf_checker u_sbhf_checker (.*);
